// ----- rtl/top_k_sorted_keeper_defines.svh -----
//------------------------------------------------------------------------------
// Top-k sorted keeper assertion macros
// Clocked, reset-qualified assertion helpers for the checker.
//------------------------------------------------------------------------------
`ifndef TOP_K_SORTED_KEEPER_DEFINES_SVH
`define TOP_K_SORTED_KEEPER_DEFINES_SVH

// Assert a property on the rising clock edge, off during reset.
`define TKSK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Assert that one condition implies another in the same cycle.
`define TKSK_ASSERT_IMP(label, cond, conseq, msg) \
  `TKSK_ASSERT(label, (cond) |-> (conseq), msg)

`endif

// ----- rtl/tksk_pkg.sv -----
//------------------------------------------------------------------------------
// Top-k sorted keeper package
// Sizes, op codes and the control word shared by the cells and the top level.
//------------------------------------------------------------------------------
package tksk_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int SCORE_W     = 32;
  localparam int IDX_W       = 6;
  localparam int KEEP_W      = 7;
  localparam int OP_W        = 2;

  localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(MAX_ENTRIES);

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_FILL   = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  typedef struct packed {
    logic ins;
    logic fill;
  } cell_ctrl_t;

endpackage

// ----- rtl/tksk_cell.sv -----
//------------------------------------------------------------------------------
// Top-k sorted keeper cell
// Holds one ranked entry; takes the new score, its left neighbor's entry or
// keeps its own, and passes its compare flag down the row.
//------------------------------------------------------------------------------
module tksk_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tksk_pkg::cell_ctrl_t        ctrl_i,
  input  logic                        active_i,
  input  logic signed [tksk_pkg::SCORE_W-1:0] score_i,
  input  logic signed [tksk_pkg::SCORE_W-1:0] prev_val_i,
  input  logic                        prev_gt_i,
  output logic signed [tksk_pkg::SCORE_W-1:0] val_o,
  output logic                        gt_o,
  output logic                        first_o
);
  import tksk_pkg::*;

  logic signed [SCORE_W-1:0] val_q, val_d;
  logic                      gt;

  assign gt      = active_i && (score_i > val_q);
  assign first_o = gt && !prev_gt_i;

  always_comb begin
    val_d = val_q;
    if (ctrl_i.fill) begin
      val_d = score_i;
    end else if (ctrl_i.ins) begin
      if (first_o) begin
        val_d = score_i;
      end else if (prev_gt_i && active_i) begin
        val_d = prev_val_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
    end else begin
      val_q <= val_d;
    end
  end

  assign val_o = val_q;
  assign gt_o  = gt;

endmodule

// ----- rtl/top_k_sorted_keeper.sv -----
//------------------------------------------------------------------------------
// Top-k sorted keeper
// Keeps the largest scores in descending order in a row of compare-and-shift
// cells. Insert, fill and read ops; one result word per op.
//------------------------------------------------------------------------------
// Timing: result on the ports in the cycle after start is taken, done_o high
//   for a single cycle; the receiver cannot stall.
// Throughput: one op per cycle, busy is never raised; every cell compares
//   and shifts in the same cycle.
// Reset: all entries zero, keep count 64, no result pending.
module top_k_sorted_keeper (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [tksk_pkg::OP_W-1:0]           op_i,
  input  logic signed [tksk_pkg::SCORE_W-1:0] score_i,
  input  logic [tksk_pkg::IDX_W-1:0]          read_index_i,
  input  logic                                cfg_we_i,
  input  logic [tksk_pkg::KEEP_W-1:0]         cfg_wdata_i,
  output logic                                done_o,
  output logic                                inserted_o,
  output logic [tksk_pkg::IDX_W-1:0]          insert_position_o,
  output logic signed [tksk_pkg::SCORE_W-1:0] entry_value_o,
  output logic                                index_beyond_o
);
  import tksk_pkg::*;

  logic [KEEP_W-1:0]         keep_q;
  logic [KEEP_W-1:0]         keep_eff;
  logic                      accept;
  cell_ctrl_t                ctrl;
  logic signed [SCORE_W-1:0] vals   [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]    gts;
  logic [MAX_ENTRIES-1:0]    firsts;
  logic [MAX_ENTRIES-1:0]    active;
  logic [IDX_W-1:0]          pos;

  logic                      done_q;
  logic                      inserted_q, inserted_d;
  logic [IDX_W-1:0]          pos_q, pos_d;
  logic signed [SCORE_W-1:0] value_q, value_d;
  logic                      beyond_q, beyond_d;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_q <= KEEP_RESET;
    end else if (cfg_we_i) begin
      keep_q <= cfg_wdata_i;
    end
  end

  // clamp count into one .. MAX_ENTRIES
  always_comb begin
    keep_eff = keep_q;
    if (keep_q == '0) begin
      keep_eff = KEEP_W'(1);
    end else if (keep_q > KEEP_W'(MAX_ENTRIES)) begin
      keep_eff = KEEP_W'(MAX_ENTRIES);
    end
  end

  always_comb begin
    ctrl = '0;
    if (accept) begin
      unique case (op_i)
        OP_INSERT: ctrl.ins  = 1'b1;
        OP_FILL:   ctrl.fill = 1'b1;
        default:   ctrl      = '0;
      endcase
    end
  end

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic signed [SCORE_W-1:0] prev_val;
    logic                      prev_gt;

    if (i == 0) begin : g_head
      assign prev_val = score_i;
      assign prev_gt  = 1'b0;
    end else begin : g_body
      assign prev_val = vals[i-1];
      assign prev_gt  = gts[i-1];
    end

    assign active[i] = KEEP_W'(i) < keep_eff;

    tksk_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .active_i   (active[i]),
      .score_i    (score_i),
      .prev_val_i (prev_val),
      .prev_gt_i  (prev_gt),
      .val_o      (vals[i]),
      .gt_o       (gts[i]),
      .first_o    (firsts[i])
    );
  end

  always_comb begin
    pos = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (firsts[i]) begin
        pos = pos | IDX_W'(i);
      end
    end
  end

  always_comb begin
    inserted_d = 1'b0;
    pos_d      = '0;
    value_d    = '0;
    beyond_d   = 1'b0;
    unique case (op_i)
      OP_INSERT: begin
        inserted_d = |gts;
        pos_d      = pos;
      end
      OP_READ: begin
        value_d  = vals[read_index_i];
        beyond_d = {1'b0, read_index_i} >= keep_eff;
      end
      default: begin
        inserted_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      inserted_q <= inserted_d;
      pos_q      <= pos_d;
      value_q    <= value_d;
      beyond_q   <= beyond_d;
    end
  end

  assign done_o            = done_q;
  assign inserted_o        = inserted_q;
  assign insert_position_o = pos_q;
  assign entry_value_o     = value_q;
  assign index_beyond_o    = beyond_q;

endmodule

// ----- rtl/tksk_checker.sv -----
//------------------------------------------------------------------------------
// Top-k sorted keeper checker
// Port-level checks on result timing and result word consistency.
//------------------------------------------------------------------------------
`include "top_k_sorted_keeper_defines.svh"

module tksk_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                start,
  input logic                                busy,
  input logic [tksk_pkg::OP_W-1:0]           op_i,
  input logic                                done_o,
  input logic                                inserted_o,
  input logic [tksk_pkg::IDX_W-1:0]          insert_position_o,
  input logic signed [tksk_pkg::SCORE_W-1:0] entry_value_o,
  input logic                                index_beyond_o
);
  import tksk_pkg::*;

  `TKSK_ASSERT(a_done_follows, (start && !busy) |=> done_o, "no result after accepted word")
  `TKSK_ASSERT(a_no_spurious, !(start && !busy) |=> !done_o, "result without accepted word")
  `TKSK_ASSERT_IMP(a_pos_zero, done_o && !inserted_o, insert_position_o == '0, "position set without insert")
  `TKSK_ASSERT_IMP(a_ins_clean, done_o && inserted_o, entry_value_o == '0 && !index_beyond_o, "read fields set on insert")
  `TKSK_ASSERT(a_fill_quiet, (start && !busy && op_i == OP_FILL) |=> !inserted_o && entry_value_o == '0, "fill returned data")

endmodule

bind top_k_sorted_keeper tksk_checker u_tksk_checker (.*);
